### rtl/core/acpi_ec_pkg.sv
package acpi_ec_pkg;

    typedef logic [2:0] t_op;
    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_phase;

    // host access kinds
    localparam t_op OP_STATUS = 3'd0;
    localparam t_op OP_DREAD  = 3'd1;
    localparam t_op OP_CMD    = 3'd2;
    localparam t_op OP_DWRITE = 3'd3;
    localparam t_op OP_POST   = 3'd4;

    // controller commands
    localparam t_byte CMD_READ  = 8'h80;
    localparam t_byte CMD_WRITE = 8'h81;
    localparam t_byte CMD_QUERY = 8'h84;

    // status byte bits
    localparam t_byte STS_OBF = 8'h01;
    localparam t_byte STS_SCI = 8'h20;

    // transaction phase
    localparam t_phase PH_IDLE    = 2'd0;
    localparam t_phase PH_RD_ADDR = 2'd1;
    localparam t_phase PH_WR_ADDR = 2'd2;
    localparam t_phase PH_WR_DATA = 2'd3;

endpackage

### rtl/core/acpi_ec_host_interface.sv
// Device side of the embedded controller command/data port pair.
// Input channel (i_in_valid / o_in_stall): one word per host access, i_op
// selects status read, data read, command write, data write or an event
// post from the controller side, i_byte_value carries the written byte.
// Output channel (o_out_valid / i_out_stall): one result word per input
// word, in order: o_read_value, o_sci_line, o_event_dropped.
// Timing: a word waits in the input register, where the RAM and event
// queue reads land, and is executed into the result register, which drives
// the outputs. One word per cycle is taken and delivered sustained while the
// receiver does not stall; the RAM and queue each need one read and one
// write port per cycle, with forwarding from the executing word.
// When the receiver stalls, the result register holds; one more word can
// wait in the input register, then o_in_stall rises.
// Reset clears the phase, OBF, data register, queue pointers and the RAM
// valid bits at once, so the RAM reads as zero until written; no clearing
// pass is needed and a word may be sent the cycle after reset.
module acpi_ec_host_interface
    import acpi_ec_pkg::*;
#(
    parameter int MEM_DEPTH   = 256,
    parameter int EVENT_DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_op,
    input  logic [7:0] i_byte_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_value,
    output logic       o_sci_line,
    output logic       o_event_dropped
);

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int QW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int CW = $clog2(EVENT_DEPTH + 1);
    localparam logic [8:0]    MEM_LIM = 9'(MEM_DEPTH);
    localparam logic [CW-1:0] Q_FULL  = CW'(EVENT_DEPTH);
    localparam logic [QW-1:0] Q_LAST  = QW'(EVENT_DEPTH - 1);

    // storage
    t_byte            r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_mem_vld;
    t_byte            r_q_mem [EVENT_DEPTH];

    // input register
    logic   r_in_vld;
    t_op    r_op;
    t_byte  r_byte;
    t_byte  r_mem_q;
    logic   r_mem_ok;
    logic   r_mem_hit;
    t_byte  r_mem_fwd;
    t_byte  r_q_q;
    logic   r_q_hit;
    t_byte  r_q_fwd;

    // controller state
    t_phase        r_phase,   n_phase;
    t_byte         r_addr,    n_addr;
    t_byte         r_obyte,   n_obyte;
    logic          r_ofull,   n_ofull;
    logic [QW-1:0] r_head,    n_head;
    logic [QW-1:0] r_tail,    n_tail;
    logic [CW-1:0] r_count,   n_count;

    // result register
    logic   r_out_vld;
    t_byte  r_rv,      n_rv;
    logic   r_sci;
    logic   r_drop,    n_drop;

    logic          advance;
    logic          in_acc;
    logic          mem_we;
    logic          q_we;
    logic [AW-1:0] mem_wr_idx;
    logic [AW-1:0] mem_rd_idx;
    logic          rd_in_range;
    t_byte         mem_data;
    t_byte         q_data;

    // handshake
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && r_out_vld && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    // read data as seen by the executing word
    assign mem_data = !r_mem_ok ? 8'h00 : (r_mem_hit ? r_mem_fwd : r_mem_q);
    assign q_data   = r_q_hit ? r_q_fwd : r_q_q;

    // execute one host access
    always_comb begin
        n_phase = r_phase;
        n_addr  = r_addr;
        n_obyte = r_obyte;
        n_ofull = r_ofull;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_rv    = 8'h00;
        n_drop  = 1'b0;
        mem_we  = 1'b0;
        q_we    = 1'b0;
        if (advance) begin
            unique case (r_op)
                OP_STATUS: begin
                    n_rv = (r_ofull ? STS_OBF : 8'h00)
                         | ((r_count != '0) ? STS_SCI : 8'h00);
                end
                OP_DREAD: begin
                    n_rv    = r_obyte;
                    n_ofull = 1'b0;
                end
                OP_CMD: begin
                    n_phase = PH_IDLE;
                    if (r_byte == CMD_READ) begin
                        n_phase = PH_RD_ADDR;
                    end else if (r_byte == CMD_WRITE) begin
                        n_phase = PH_WR_ADDR;
                    end else if (r_byte == CMD_QUERY) begin
                        n_ofull = 1'b1;
                        if (r_count != '0) begin
                            n_obyte = q_data;
                            n_head  = (r_head == Q_LAST) ? '0 : r_head + 1'b1;
                            n_count = r_count - 1'b1;
                        end else begin
                            n_obyte = 8'h00;
                        end
                    end
                end
                OP_DWRITE: begin
                    unique case (r_phase)
                        PH_RD_ADDR: begin
                            n_obyte = mem_data;
                            n_ofull = 1'b1;
                            n_phase = PH_IDLE;
                        end
                        PH_WR_ADDR: begin
                            n_addr  = r_byte;
                            n_phase = PH_WR_DATA;
                        end
                        PH_WR_DATA: begin
                            mem_we  = ({1'b0, r_addr} < MEM_LIM);
                            n_phase = PH_IDLE;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
                OP_POST: begin
                    if (r_count < Q_FULL) begin
                        q_we    = 1'b1;
                        n_tail  = (r_tail == Q_LAST) ? '0 : r_tail + 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                end
                default: begin
                    n_rv = 8'h00;
                end
            endcase
        end
    end

    assign mem_wr_idx  = r_addr[AW-1:0];
    assign mem_rd_idx  = i_byte_value[AW-1:0];
    assign rd_in_range = ({1'b0, i_byte_value} < MEM_LIM);

    // controller ram: write from execution, read for the incoming word
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wr_idx] <= r_byte;
        end
        if (in_acc) begin
            r_mem_q <= r_mem[mem_rd_idx];
        end
    end

    // event queue: push at tail, read the head the incoming word will see
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q_mem[r_tail] <= r_byte;
        end
        if (in_acc) begin
            r_q_q <= r_q_mem[n_head];
        end
    end

    // input register payload with valid-bit and forwarding info
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op      <= i_op;
            r_byte    <= i_byte_value;
            r_mem_ok  <= rd_in_range && (r_mem_vld[mem_rd_idx]
                         || (mem_we && mem_wr_idx == mem_rd_idx));
            r_mem_hit <= mem_we && (mem_wr_idx == mem_rd_idx);
            r_mem_fwd <= r_byte;
            r_q_hit   <= q_we && (r_tail == n_head);
            r_q_fwd   <= r_byte;
        end
    end

    // ram valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (mem_we) begin
            r_mem_vld[mem_wr_idx] <= 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_IDLE;
            r_addr    <= 8'h00;
            r_obyte   <= 8'h00;
            r_ofull   <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
        end else begin
            r_in_vld  <= in_acc || (r_in_vld && !advance);
            r_out_vld <= advance || (r_out_vld && i_out_stall);
            r_phase   <= n_phase;
            r_addr    <= n_addr;
            r_obyte   <= n_obyte;
            r_ofull   <= n_ofull;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rv   <= n_rv;
            r_sci  <= (n_count != '0);
            r_drop <= n_drop;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_read_value    = r_rv;
    assign o_sci_line      = r_sci;
    assign o_event_dropped = r_drop;

`ifndef SYNTHESIS
    // queue fill never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_FULL)
        else $error("event queue count beyond depth");

    // a dropped event means the queue was full, so sci stays up
    a_drop_sci: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_dropped |-> o_sci_line)
        else $error("event dropped without sci");

    // data phase is entered only after the address phase of a write
    a_wr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WR_DATA) && ($past(r_phase) != PH_WR_DATA)
        |-> $past(r_phase) == PH_WR_ADDR)
        else $error("write data phase without address phase");

    // input side stalls only when both stages are held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall && r_in_vld)
        else $error("input stalled without a full pipeline");
`endif

endmodule
